// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the decoder back end.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge out of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/core/ehpd_pkg.sv =====
// Shared types, constants and helpers for the hex preview decoder.
// No dependencies.
package ehpd_pkg;

    localparam int LINE_BITS_MAX_DEF = 65535;
    localparam int QUEUE_DEPTH_DEF   = 4;
    localparam int BUF_BITS          = 19;
    localparam int CNT_W             = 5;

    localparam logic [7:0] CHAR_PCT = 8'h25;   // '%'
    localparam logic [7:0] CHAR_0   = 8'h30;
    localparam logic [7:0] CHAR_LA  = 8'h61;   // 'a'
    localparam logic [7:0] CHAR_UA  = 8'h41;   // 'A'
    localparam logic [3:0] HEX_TEN  = 4'd10;

    // configuration register indexes
    localparam logic CFG_LINE_BITS  = 1'b0;
    localparam logic CFG_BYTE_LIMIT = 1'b1;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex       h;
        logic [7:0] d;
        h = '0;
        d = '0;
        case (c) inside
            [8'h30:8'h39]: begin
                d     = c - CHAR_0;
                h.ok  = 1'b1;
                h.val = d[3:0];
            end
            [8'h61:8'h66]: begin
                d     = c - CHAR_LA;
                h.ok  = 1'b1;
                h.val = d[3:0] + HEX_TEN;
            end
            [8'h41:8'h46]: begin
                d     = c - CHAR_UA;
                h.ok  = 1'b1;
                h.val = d[3:0] + HEX_TEN;
            end
            default: h = '0;
        endcase
        return h;
    endfunction

endpackage

// ===== rtl/core/ehpd_front.sv =====
// Front end: accepts characters, tracks comment lines, extracts hex digits.
// Depends on ehpd_pkg.
module ehpd_front
    import ehpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char,
    input  logic       i_first,
    input  t_fifo_stat i_q_stat,
    output logic       o_push,
    output logic [3:0] o_nib
);

    logic r_skip_line;
    logic n_skip_line;
    logic accept;
    logic skip_now;
    t_hex hex;

    always_comb begin
        o_ready     = !i_q_stat.full;
        accept      = i_valid && o_ready;
        skip_now    = i_first ? (i_char != CHAR_PCT) : r_skip_line;
        hex         = hex_value(i_char);
        o_push      = accept && !skip_now && hex.ok;
        o_nib       = hex.val;
        n_skip_line = accept ? skip_now : r_skip_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_line <= 1'b0;
        end else begin
            r_skip_line <= n_skip_line;
        end
    end

endmodule

// ===== rtl/core/ehpd_fifo.sv =====
// Small register queue of hex digits between front and back end.
// Depends on ehpd_pkg.
module ehpd_fifo
    import ehpd_pkg::*;
#(
    parameter int WIDTH = 4,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_din,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_dout,
    output t_fifo_stat       o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic [PW-1:0]    n_wp, n_rp;
    logic [CW-1:0]    n_cnt;
    logic             do_push, do_pop;

    always_comb begin
        o_stat.full  = (r_cnt == CNT_FULL);
        o_stat.empty = (r_cnt == '0);
        do_push      = i_push && !o_stat.full;
        do_pop       = i_pop && !o_stat.empty;
        o_dout       = r_mem[r_rp];
        n_wp         = do_push ? ((r_wp == PTR_LAST) ? '0 : r_wp + 1'b1) : r_wp;
        n_rp         = do_pop  ? ((r_rp == PTR_LAST) ? '0 : r_rp + 1'b1) : r_rp;
        n_cnt        = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/ehpd_back.sv =====
// Back end: packs hex digits into bytes, drops scan line pad bits,
// counts bytes against the limit. Depends on ehpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ehpd_back
    import ehpd_pkg::*;
#(
    parameter int LINE_BITS_MAX = LINE_BITS_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_line_bits,
    input  logic [24:0] i_byte_limit,
    input  logic [3:0]  i_nib,
    input  t_fifo_stat  i_q_stat,
    output logic        o_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tuser
);

    localparam logic [15:0]      LB_MAX    = 16'(LINE_BITS_MAX);
    localparam logic [24:0]      BYTES_SAT = '1;
    localparam logic [CNT_W-1:0] CNT_SAT   = CNT_W'(BUF_BITS);
    localparam logic [CNT_W-1:0] CNT_BYTE  = CNT_W'(8);

    logic [BUF_BITS-1:0] r_bb, n_bb;
    logic [CNT_W-1:0]    r_bc, n_bc;
    logic [13:0]         r_cis, n_cis;
    logic [24:0]         r_bytes, n_bytes;
    logic                r_halted, n_halted;
    logic                r_out_valid, n_out_valid;
    logic [7:0]          r_out_byte, n_out_byte;
    logic                r_out_ovf, n_out_ovf;

    logic [15:0]         lb;
    logic [16:0]         lb_sum;
    logic [14:0]         hex_per;
    logic [2:0]          pad;
    logic [BUF_BITS-1:0] sh, bb1, bb_hi, mask;
    logic [CNT_W-1:0]    cnt4, bc1, bc2;
    logic [14:0]         pos;
    logic                endl, emit, ovf, work;
    logic [24:0]         bytes_new;

    always_comb begin
        lb = (i_line_bits > LB_MAX) ? LB_MAX : i_line_bits;
        if (lb == '0) begin
            lb = 16'd1;
        end
        lb_sum  = {1'b0, lb} + 17'd7;
        hex_per = {lb_sum[16:3], 1'b0};
        pad     = 3'd0 - lb[2:0];

        // a halted block drains the queue without working
        o_pop = !i_q_stat.empty && (r_halted || !r_out_valid || i_m_tready);
        work  = o_pop && !r_halted;

        sh   = {r_bb[BUF_BITS-5:0], i_nib};
        cnt4 = (r_bc > CNT_SAT - 5'd4) ? CNT_SAT : r_bc + 5'd4;
        pos  = {1'b0, r_cis} + 15'd1;
        endl = (pos >= hex_per);

        bb1 = sh;
        bc1 = cnt4;
        if (endl) begin
            if (cnt4 < {2'b00, pad}) begin
                bb1 = '0;
                bc1 = '0;
            end else begin
                bb1 = sh >> pad;
                bc1 = cnt4 - {2'b00, pad};
            end
        end

        emit      = (bc1 >= CNT_BYTE + {2'b00, pad});
        bc2       = bc1 - CNT_BYTE;
        bb_hi     = bb1 >> bc2;
        mask      = (BUF_BITS'(1) << bc2) - BUF_BITS'(1);
        bytes_new = (r_bytes == BYTES_SAT) ? r_bytes : r_bytes + 25'd1;
        ovf       = (bytes_new >= i_byte_limit);

        n_bb        = r_bb;
        n_bc        = r_bc;
        n_cis       = r_cis;
        n_bytes     = r_bytes;
        n_halted    = r_halted;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_byte  = r_out_byte;
        n_out_ovf   = r_out_ovf;

        if (work) begin
            n_cis = endl ? '0 : pos[13:0];
            if (emit) begin
                n_bb        = bb1 & mask;
                n_bc        = bc2;
                n_bytes     = bytes_new;
                n_halted    = ovf;
                n_out_valid = 1'b1;
                n_out_byte  = bb_hi[7:0];
                n_out_ovf   = ovf;
            end else begin
                n_bb = bb1;
                n_bc = bc1;
            end
        end

        o_m_tvalid = r_out_valid;
        o_m_tdata  = r_out_byte;
        o_m_tuser  = r_out_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bb        <= '0;
            r_bc        <= '0;
            r_cis       <= '0;
            r_bytes     <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_bb        <= n_bb;
            r_bc        <= n_bc;
            r_cis       <= n_cis;
            r_bytes     <= n_bytes;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_ovf  <= n_out_ovf;
    end

    `ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_bc > CNT_SAT, "bit count past buffer width")
    `ASSERT_PROP(a_ovf_halts, i_clk, i_rst_n,
                 r_out_valid && r_out_ovf |-> r_halted, "overflow byte without halt")
    `ASSERT_PROP(a_quiet_halt, i_clk, i_rst_n,
                 r_halted && !r_out_valid |=> !r_out_valid, "byte after halt")
    `ASSERT_PROP(a_pop_nonempty, i_clk, i_rst_n, o_pop |-> !i_q_stat.empty, "pop from empty queue")

endmodule

// ===== rtl/core/epsi_hex_preview_decoder.sv =====
// Hex preview decoder top: config registers, front end, digit queue, back end.
// A byte is valid on the master side in the cycle after its last digit leaves the queue.
// Throughput: one character per cycle while the digit queue is not full.
// Back-pressure on the master side fills the digit queue, then drops tready on the slave side.
// Reset (synchronous, active low) empties the queue, clears all decode state and
// loads line_bits = 8, byte_limit = 1; no clearing pass is needed.
module epsi_hex_preview_decoder
    import ehpd_pkg::*;
#(
    parameter int LINE_BITS_MAX = LINE_BITS_MAX_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [24:0] i_cfg_wdata,
    // character stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_code
    input  logic        i_s_axis_tuser,   // [0] first_of_line
    // byte stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_byte
    output logic        o_m_axis_tuser    // [0] overflow
);

    logic [15:0] r_line_bits, n_line_bits;
    logic [24:0] r_byte_limit, n_byte_limit;
    logic        push, pop;
    logic [3:0]  push_nib, head_nib;
    t_fifo_stat  q_stat;

    always_comb begin
        n_line_bits  = r_line_bits;
        n_byte_limit = r_byte_limit;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_BITS:  n_line_bits  = i_cfg_wdata[15:0];
                CFG_BYTE_LIMIT: n_byte_limit = i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bits  <= 16'd8;
            r_byte_limit <= 25'd1;
        end else begin
            r_line_bits  <= n_line_bits;
            r_byte_limit <= n_byte_limit;
        end
    end

    ehpd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_char   (i_s_axis_tdata),
        .i_first  (i_s_axis_tuser),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_nib    (push_nib)
    );

    ehpd_fifo #(
        .WIDTH (4),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   (push_nib),
        .i_pop   (pop),
        .o_dout  (head_nib),
        .o_stat  (q_stat)
    );

    ehpd_back #(
        .LINE_BITS_MAX (LINE_BITS_MAX)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_bits  (r_line_bits),
        .i_byte_limit (r_byte_limit),
        .i_nib        (head_nib),
        .i_q_stat     (q_stat),
        .o_pop        (pop),
        .o_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .o_m_tdata    (o_m_axis_tdata),
        .o_m_tuser    (o_m_axis_tuser)
    );

endmodule
